### design/b64d_pkg.sv
// base64 decoder package: field widths, state and result structs, character
// classification function; shared by the interfaces, the step logic and the top level
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int POS_W    = 2;
    localparam int COUNT_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // classification of one input character
    typedef struct packed {
        logic                is_bad;
        logic                is_ws;
        logic [SEXTET_W-1:0] sextet;
    } char_class_t;

    // decoder state carried from one character to the next
    typedef struct packed {
        logic [SEXTET_W-1:0] left;
        logic [POS_W-1:0]    pos;
        logic                err;
        logic [COUNT_W-1:0]  count;
    } dec_state_t;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               error;
        logic               done_res;
        logic [COUNT_W-1:0] byte_total;
    } dec_result_t;

    // step logic outcome for one character
    typedef struct packed {
        logic        produce;
        dec_result_t result;
        dec_state_t  state_next;
    } dec_step_t;

    localparam dec_state_t STATE_RESET = '{
        left:  '0,
        pos:   '0,
        err:   1'b0,
        count: '0
    };

    // map an ASCII byte to its sextet, whitespace or bad
    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        char_class_t r;
        r = '{is_bad: 1'b0, is_ws: 1'b0, sextet: '0};
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.sextet = SEXTET_W'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r.sextet = SEXTET_W'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r.sextet = SEXTET_W'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            r.sextet = SEXTET_W'(62);
        end
        else if (c == 8'h2F) begin
            r.sextet = SEXTET_W'(63);
        end
        else if (c == 8'h20 || c == 8'h0A || c == 8'h0D) begin
            r.is_ws = 1'b1;
        end
        else begin
            r.is_bad = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/b64d_char_if.sv
// character channel: valid/ready handshake with one input character per transaction
// depends on b64d_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface b64d_char_if;
    import b64d_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              last;

    modport source (output valid, output in_char, output last, input ready);
    modport sink   (input valid, input in_char, input last, output ready);
endinterface

`default_nettype wire

### design/b64d_result_if.sv
// result channel: valid/ready handshake with one decoded result per transaction
// depends on b64d_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface b64d_result_if;
    import b64d_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               error;
    logic               done_res;
    logic [COUNT_W-1:0] byte_total;

    modport source (output valid, output out_byte, output byte_valid, output error,
                    output done_res, output byte_total, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input error,
                    input done_res, input byte_total, output ready);
endinterface

`default_nettype wire

### design/b64d_step.sv
// combinational step logic: decodes one character against the current state
// depends on b64d_pkg for types and the classify function
`timescale 1ns / 1ps
`default_nettype none

module b64d_step (
    input  wire  logic [b64d_pkg::CHAR_W-1:0] in_char,
    input  wire  logic                        last,
    input  wire  b64d_pkg::dec_state_t        state,
    output       b64d_pkg::dec_step_t         step
);
    import b64d_pkg::*;

    char_class_t       cls;
    dec_state_t        st;
    logic              have_byte;
    logic [BYTE_W-1:0] byte_val;

    assign cls = classify(in_char);

    // sextet assembly, error latch and saturating count
    always_comb
    begin
        st        = state;
        have_byte = 1'b0;
        byte_val  = '0;
        if (!state.err) begin
            if (cls.is_bad) begin
                st.err = 1'b1;
            end
            else if (!cls.is_ws) begin
                case (state.pos)
                    2'd0:
                    begin
                        st.left = cls.sextet;
                    end
                    2'd1:
                    begin
                        byte_val  = {state.left[5:0], cls.sextet[5:4]};
                        st.left   = {2'b00, cls.sextet[3:0]};
                        have_byte = 1'b1;
                    end
                    2'd2:
                    begin
                        byte_val  = {state.left[3:0], cls.sextet[5:2]};
                        st.left   = {4'b0000, cls.sextet[1:0]};
                        have_byte = 1'b1;
                    end
                    default:
                    begin
                        byte_val  = {state.left[1:0], cls.sextet};
                        st.left   = '0;
                        have_byte = 1'b1;
                    end
                endcase
                st.pos = state.pos + POS_W'(1);
                if (have_byte && state.count != COUNT_MAX) begin
                    st.count = state.count + COUNT_W'(1);
                end
            end
        end
        // a lone sextet in the final group is a bad tail
        if (last && !st.err && st.pos == POS_W'(1)) begin
            st.err = 1'b1;
        end
    end

    // result fields and state for the next character
    always_comb
    begin
        step.produce           = have_byte || last;
        step.result.out_byte   = byte_val;
        step.result.byte_valid = have_byte;
        step.result.error      = st.err;
        step.result.done_res   = last;
        step.result.byte_total = st.count;
        step.state_next        = last ? STATE_RESET : st;
    end

endmodule

`default_nettype wire

### design/base64_decode_skip_whitespace.sv
// streaming base64 decoder top level: input register, step logic, result register
// depends on b64d_pkg, b64d_char_if, b64d_result_if and b64d_step
//
// usage:
//   chars   - one ASCII character per transaction, with last on the final one
//   results - one per decoded byte or last character, one if both; on the last
//             done_res = 1, byte_total = final count, error = stream status
//   whitespace (space, LF, CR) is dropped; any other non-alphabet byte sets
//   the error latch, after which characters are consumed but decode nothing
// path: an accepted character enters the input register, the step logic decodes it and
//   its result is held in the result register and shown on the result channel
// throughput: one character per cycle while results are taken; the input
//   and result registers let a character enter while a result waits to be taken
// stall: when the result register is full and not taken, a character that
//   yields a result holds in the input register and chars.ready drops
// reset: rst_n clears all decode state, the count and both valid flags;
//   decode state also returns to reset after each last character
`timescale 1ns / 1ps
`default_nettype none

module base64_decode_skip_whitespace (
    input  wire logic     clk,
    input  wire logic     rst_n,
    b64d_char_if.sink     chars,
    b64d_result_if.source results
);
    import b64d_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    dec_state_t        state_reg;
    dec_step_t         step;

    logic              out_valid_reg;
    logic              out_valid_next;
    dec_result_t       out_reg;

    logic              out_free;
    logic              advance;

    b64d_step u_step (
        .in_char (in_char_reg),
        .last    (in_last_reg),
        .state   (state_reg),
        .step    (step)
    );

    // handshake control
    assign out_free    = !out_valid_reg || results.ready;
    assign advance     = in_valid_reg && (!step.produce || out_free);
    assign chars.ready = !in_valid_reg || advance;

    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        if (advance && step.produce) begin
            out_valid_next = 1'b1;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready) begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready) begin
            in_char_reg <= chars.in_char;
            in_last_reg <= chars.last;
        end
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
        end
        else if (advance) begin
            state_reg <= step.state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.produce) begin
            out_reg <= step.result;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_byte   = out_reg.out_byte;
    assign results.byte_valid = out_reg.byte_valid;
    assign results.error      = out_reg.error;
    assign results.done_res   = out_reg.done_res;
    assign results.byte_total = out_reg.byte_total;

endmodule

`default_nettype wire

### dv/tb.sv
// testbench for base64_decode_skip_whitespace: directed table, then random streams
// depends on b64d_pkg, b64d_char_if, b64d_result_if and the decoder top level
`timescale 1ns / 1ps

module tb;
    import b64d_pkg::*;

    localparam int ITEM_TARGET  = 1950;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT      = 1300;
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;
    localparam int IDLE_PCT     = 17;
    localparam int SHOW_MAX     = 10;

    // special characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    // classifier codes beyond the 0..63 sextet range
    localparam logic [7:0] CODE_SPACE = 8'h40;
    localparam logic [7:0] CODE_BAD   = 8'h80;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        has_want;
        dec_result_t want;
    } script_row_t;

    logic clk;
    logic rst_n;

    b64d_char_if   chars_if ();
    b64d_result_if results_if ();

    base64_decode_skip_whitespace u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    // decoder state mirror
    logic [5:0]  tail_bits;
    logic [1:0]  grp_pos;
    logic        err_seen;
    logic [31:0] byte_cnt;

    dec_result_t want_q[$];
    script_row_t script_q[$];

    int n_fail;
    int n_sent;
    int n_streams;
    int n_bytes;
    int n_err_streams;
    int cycle_cnt;
    bit calm;
    bit hold_done;

    always #5 clk = ~clk;

    // map a character to its sextet, or to the whitespace / bad code
    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c - "A";
        if (c >= "a" && c <= "z")
            return c - "a" + 8'd26;
        if (c >= "0" && c <= "9")
            return c - "0" + 8'd52;
        if (c == CH_PLUS)
            return 8'd62;
        if (c == CH_SLASH)
            return 8'd63;
        if (c == CH_SPACE || c == CH_LF || c == CH_CR)
            return CODE_SPACE;
        return CODE_BAD;
    endfunction

    // inverse alphabet, for building random streams
    function automatic logic [7:0] char_of(input logic [5:0] s);
        if (s < 26)
            return "A" + 8'(s);
        if (s < 52)
            return "a" + 8'(s - 26);
        if (s < 62)
            return "0" + 8'(s - 52);
        return (s == 6'd62) ? CH_PLUS : CH_SLASH;
    endfunction

    function automatic script_row_t row_open(input logic [7:0] c, input logic l);
        script_row_t r;
        r = '0;
        r.ch = c;
        r.last = l;
        return r;
    endfunction

    function automatic script_row_t row_known(input logic [7:0] c, input logic l,
                                              input logic [7:0] b, input logic bv,
                                              input logic e, input logic d,
                                              input logic [31:0] total);
        script_row_t r;
        r = row_open(c, l);
        r.has_want = 1'b1;
        r.want.out_byte = b;
        r.want.byte_valid = bv;
        r.want.error = e;
        r.want.done_res = d;
        r.want.byte_total = total;
        return r;
    endfunction

    // advance the state mirror by one character and form its result, if any
    task automatic decode_step(input logic [7:0] c, input logic l,
                               output bit produce, output dec_result_t res);
        logic [7:0] code;
        logic [7:0] b;
        bit have;
        have = 1'b0;
        b = '0;
        if (!err_seen) begin
            code = sextet_of(c);
            if (code == CODE_BAD) begin
                err_seen = 1'b1;
            end
            else if (code != CODE_SPACE) begin
                case (grp_pos)
                    2'd0:
                    begin
                        tail_bits = code[5:0];
                    end
                    2'd1:
                    begin
                        b = {tail_bits, code[5:4]};
                        tail_bits = {2'b00, code[3:0]};
                        have = 1'b1;
                    end
                    2'd2:
                    begin
                        b = {tail_bits[3:0], code[5:2]};
                        tail_bits = {4'b0000, code[1:0]};
                        have = 1'b1;
                    end
                    default:
                    begin
                        b = {tail_bits[1:0], code[5:0]};
                        tail_bits = '0;
                        have = 1'b1;
                    end
                endcase
                grp_pos = grp_pos + 2'd1;
                if (have && byte_cnt != '1)
                    byte_cnt = byte_cnt + 32'd1;
            end
        end
        // a lone sextet in the final group is a bad tail
        if (l && !err_seen && grp_pos == 2'd1)
            err_seen = 1'b1;
        produce = have || l;
        res.out_byte = have ? b : 8'h00;
        res.byte_valid = have;
        res.error = err_seen;
        res.done_res = l;
        res.byte_total = byte_cnt;
        if (l) begin
            tail_bits = '0;
            grp_pos = '0;
            err_seen = 1'b0;
            byte_cnt = '0;
        end
    endtask

    // offer one character, starting and ending at a falling edge
    task automatic send_char(input logic [7:0] c, input logic l,
                             input logic has_want, input dec_result_t want);
        bit produce;
        dec_result_t res;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.in_char <= c;
        chars_if.last <= l;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        decode_step(c, l, produce, res);
        if (produce)
            want_q.push_back(has_want ? want : res);
        n_sent++;
        calm = (n_sent >= CALM_FROM && n_sent < CALM_TO);
        @(negedge clk);
    endtask

    // cycle limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_cnt, want_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result check against the oldest expectation
    always @(posedge clk) begin : check_results
        dec_result_t got;
        dec_result_t want;
        if (rst_n && results_if.valid && results_if.ready) begin
            got.out_byte = results_if.out_byte;
            got.byte_valid = results_if.byte_valid;
            got.error = results_if.error;
            got.done_res = results_if.done_res;
            got.byte_total = results_if.byte_total;
            if (want_q.size() == 0) begin
                n_fail++;
                if (n_fail <= SHOW_MAX)
                    $display("[%0t] unexpected result: byte %02h valid %0b error %0b done %0b total %0d",
                             $time, got.out_byte, got.byte_valid, got.error, got.done_res,
                             got.byte_total);
            end
            else begin
                want = want_q.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.error !== want.error || got.done_res !== want.done_res ||
                    got.byte_total !== want.byte_total) begin
                    n_fail++;
                    if (n_fail <= SHOW_MAX) begin
                        $display("[%0t] mismatch expected: byte %02h valid %0b error %0b done %0b total %0d",
                                 $time, want.out_byte, want.byte_valid, want.error,
                                 want.done_res, want.byte_total);
                        $display("[%0t] mismatch actual:   byte %02h valid %0b error %0b done %0b total %0d",
                                 $time, got.out_byte, got.byte_valid, got.error, got.done_res,
                                 got.byte_total);
                    end
                end
                if (want.byte_valid)
                    n_bytes++;
                if (want.done_res) begin
                    n_streams++;
                    if (want.error)
                        n_err_streams++;
                end
            end
        end
    end

    // result side: random back-pressure, one long hold-off mid run
    initial begin : result_side
        int i;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                results_if.ready <= 1'b0;
                for (i = 0; i < HOLD_CYCLES; i++)
                    @(negedge clk);
            end
            results_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // reset, directed table, random streams, drain
    initial begin : char_side
        script_row_t r;
        logic [7:0] c;
        int kind;
        int len;
        int bad_at;
        int k;
        clk = 1'b0;
        rst_n = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.in_char = '0;
        chars_if.last = 1'b0;
        results_if.ready = 1'b0;
        tail_bits = '0;
        grp_pos = '0;
        err_seen = 1'b0;
        byte_cnt = '0;
        n_fail = 0;
        n_sent = 0;
        n_streams = 0;
        n_bytes = 0;
        n_err_streams = 0;
        cycle_cnt = 0;
        calm = 1'b0;
        hold_done = 1'b0;

        // plain group, whitespace, three-sextet tail, lone sextet, two-sextet tail,
        // whitespace as last, error runs, high and low bytes
        script_q.push_back(row_open("T", 1'b0));
        script_q.push_back(row_known("W", 1'b0, 8'h4D, 1'b1, 1'b0, 1'b0, 32'd1));
        script_q.push_back(row_known("F", 1'b0, 8'h61, 1'b1, 1'b0, 1'b0, 32'd2));
        script_q.push_back(row_known("u", 1'b0, 8'h6E, 1'b1, 1'b0, 1'b0, 32'd3));
        script_q.push_back(row_open(CH_SPACE, 1'b0));
        script_q.push_back(row_open(CH_LF, 1'b0));
        script_q.push_back(row_open(CH_CR, 1'b0));
        script_q.push_back(row_open(CH_PLUS, 1'b0));
        script_q.push_back(row_known(CH_SLASH, 1'b0, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd4));
        script_q.push_back(row_known(CH_SLASH, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b1, 32'd5));
        script_q.push_back(row_known("A", 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 32'd0));
        script_q.push_back(row_open("z", 1'b0));
        script_q.push_back(row_known("9", 1'b1, 8'hCF, 1'b1, 1'b0, 1'b1, 32'd1));
        script_q.push_back(row_known(CH_SPACE, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 32'd0));
        script_q.push_back(row_open(CH_PAD, 1'b0));
        script_q.push_back(row_open("Q", 1'b0));
        script_q.push_back(row_open(8'hFF, 1'b0));
        script_q.push_back(row_known(CH_LF, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 32'd0));
        script_q.push_back(row_known(8'h80, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 32'd0));
        script_q.push_back(row_known(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 32'd0));
        script_q.push_back(row_open("Q", 1'b0));
        script_q.push_back(row_known("Q", 1'b0, 8'h41, 1'b1, 1'b0, 1'b0, 32'd1));
        script_q.push_back(row_known(8'h7F, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 32'd1));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script_q[i]) begin
            r = script_q[i];
            send_char(r.ch, r.last, r.has_want, r.want);
        end

        // random streams: mostly well formed, some broken by one byte, some pure noise
        while (n_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            bad_at = $urandom_range(0, len - 1);
            for (k = 0; k < len; k++) begin
                if (kind < 10 || (kind < 25 && k == bad_at)) begin
                    c = 8'($urandom_range(0, 255));
                end
                else if ($urandom_range(0, 99) < 8) begin
                    case ($urandom_range(0, 2))
                        0: c = CH_SPACE;
                        1: c = CH_LF;
                        default: c = CH_CR;
                    endcase
                end
                else begin
                    c = char_of(6'($urandom_range(0, 63)));
                end
                send_char(c, k == len - 1, 1'b0, '0);
            end
        end
        chars_if.valid <= 1'b0;

        while (want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters in %0d streams (%0d ended in error), %0d bytes checked",
                 n_sent, n_streams, n_err_streams, n_bytes);
        $display("directed tails and bad bytes, random streams, %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (n_fail == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
design/b64d_pkg.sv
design/b64d_char_if.sv
design/b64d_result_if.sv
design/b64d_step.sv
design/base64_decode_skip_whitespace.sv
dv/tb.sv
